[rtl/lps_pkg.sv]
`timescale 1ns / 1ps

package lps_pkg;

  typedef enum logic [0:0] {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_t;

  localparam int QUEUE_DEPTH = 2;

endpackage

[rtl/lps_front.sv]
`timescale 1ns / 1ps

module lps_front import lps_pkg::*; #(
  parameter int CB = 12,
  parameter int ENTRY_W = 6 * CB + 4,
  parameter int IN_TDATA_W = ((4 * CB + 7) / 8) * 8
) (
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic                  in_tuser,
  input  logic                  q_full,
  output logic                  q_push,
  output logic [ENTRY_W-1:0]    q_wdata
);

  logic signed [CB-1:0] xs, ys, xe, ye;
  logic signed [CB:0]   dx, dy;
  logic [CB-1:0]        spx, spy;
  logic                 xd, yd, act;
  op_t                  op;

  assign xs = in_tdata[CB-1:0];
  assign ys = in_tdata[2*CB-1:CB];
  assign xe = in_tdata[3*CB-1:2*CB];
  assign ye = in_tdata[4*CB-1:3*CB];
  assign op = op_t'(in_tuser);

  // Deltas widened by one bit so the subtraction cannot wrap.
  assign dx = {xe[CB-1], xe} - {xs[CB-1], xs};
  assign dy = {ye[CB-1], ye} - {ys[CB-1], ys};

  always_comb begin
    logic signed [CB:0] ax, ay;
    ax  = dx[CB] ? -dx : dx;
    ay  = dy[CB] ? -dy : dy;
    spx = ax[CB-1:0];
    spy = ay[CB-1:0];
    xd  = dx[CB] || (dx == '0);
    yd  = dy[CB] || (dy == '0);
    act = (dx != '0) || (dy != '0);
  end

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;
  // Entry, lowest bits first: op, xs, ys, xe, ye, span_x, span_y, x_down, y_down, active.
  assign q_wdata   = {act, yd, xd, spy, spx, ye, xe, ys, xs, op};

endmodule

[rtl/lps_queue.sv]
`timescale 1ns / 1ps

module lps_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] rdata
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign valid = (cnt_r != '0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

[rtl/lps_back.sv]
`timescale 1ns / 1ps

module lps_back import lps_pkg::*; #(
  parameter int CB = 12,
  parameter int ENTRY_W = 6 * CB + 4,
  parameter int OUT_TDATA_W = ((2 * CB + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  logic [ENTRY_W-1:0]     q_rdata,
  output logic                   q_pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tuser,
  output logic                   out_tlast
);

  localparam int ERR_W = CB + 2;
  localparam int E2_W  = CB + 3;

  op_t           e_op;
  logic [CB-1:0] e_xs, e_ys, e_xe, e_ye, e_spx, e_spy;
  logic          e_xd, e_yd, e_act;

  assign {e_act, e_yd, e_xd, e_spy, e_spx, e_ye, e_xe, e_ys, e_xs} = q_rdata[ENTRY_W-1:1];
  assign e_op = op_t'(q_rdata[0]);

  logic [CB-1:0]    cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [CB-1:0]    end_x_r, end_x_nxt, end_y_r, end_y_nxt;
  logic [CB-1:0]    spx_r, spx_nxt, spy_r, spy_nxt;
  logic             xd_r, xd_nxt, yd_r, yd_nxt, act_r, act_nxt;
  logic [ERR_W-1:0] err_r, err_nxt;

  logic             ov_r, ov_nxt, opv_r, opv_nxt, olast_r, olast_nxt;
  logic [CB-1:0]    ox_r, ox_nxt, oy_r, oy_nxt;

  logic             fire;
  logic signed [E2_W-1:0] e2, spx_e, spy_e, err_e, err_sum;
  logic             cx, cy;
  logic [CB-1:0]    sx, sy;

  assign fire  = q_valid && (!ov_r || out_tready);
  assign q_pop = fire;

  assign e2    = {err_r, 1'b0};
  assign spx_e = {3'b000, spx_r};
  assign spy_e = {3'b000, spy_r};
  assign err_e = {err_r[ERR_W-1], err_r};
  assign cx    = e2 > -spy_e;
  assign cy    = e2 < spx_e;
  assign err_sum = err_e - (cx ? spy_e : '0) + (cy ? spx_e : '0);
  assign sx = !cx ? cur_x_r : (xd_r ? cur_x_r - 1'b1 : cur_x_r + 1'b1);
  assign sy = !cy ? cur_y_r : (yd_r ? cur_y_r - 1'b1 : cur_y_r + 1'b1);

  always_comb begin
    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    end_x_nxt = end_x_r;
    end_y_nxt = end_y_r;
    spx_nxt   = spx_r;
    spy_nxt   = spy_r;
    xd_nxt    = xd_r;
    yd_nxt    = yd_r;
    act_nxt   = act_r;
    err_nxt   = err_r;
    ov_nxt    = ov_r && !out_tready;
    opv_nxt   = opv_r;
    olast_nxt = olast_r;
    ox_nxt    = ox_r;
    oy_nxt    = oy_r;
    if (fire) begin
      ov_nxt = 1'b1;
      unique case (e_op)
        OP_START: begin
          cur_x_nxt = e_xs;
          cur_y_nxt = e_ys;
          end_x_nxt = e_xe;
          end_y_nxt = e_ye;
          spx_nxt   = e_spx;
          spy_nxt   = e_spy;
          xd_nxt    = e_xd;
          yd_nxt    = e_yd;
          act_nxt   = e_act;
          err_nxt   = {2'b00, e_spx} - {2'b00, e_spy};
          ox_nxt    = e_xe;
          oy_nxt    = e_ye;
          opv_nxt   = 1'b1;
          olast_nxt = !e_act;
        end
        OP_STEP: begin
          if (act_r) begin
            ox_nxt    = cur_x_r;
            oy_nxt    = cur_y_r;
            opv_nxt   = 1'b1;
            olast_nxt = (sx == end_x_r) && (sy == end_y_r);
            cur_x_nxt = sx;
            cur_y_nxt = sy;
            err_nxt   = err_sum[ERR_W-1:0];
            act_nxt   = !olast_nxt;
          end else begin
            ox_nxt    = '0;
            oy_nxt    = '0;
            opv_nxt   = 1'b0;
            olast_nxt = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r <= '0;
      cur_y_r <= '0;
      end_x_r <= '0;
      end_y_r <= '0;
      spx_r   <= '0;
      spy_r   <= '0;
      xd_r    <= 1'b0;
      yd_r    <= 1'b0;
      act_r   <= 1'b0;
      err_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
      end_x_r <= end_x_nxt;
      end_y_r <= end_y_nxt;
      spx_r   <= spx_nxt;
      spy_r   <= spy_nxt;
      xd_r    <= xd_nxt;
      yd_r    <= yd_nxt;
      act_r   <= act_nxt;
      err_r   <= err_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    opv_r   <= opv_nxt;
    olast_r <= olast_nxt;
    ox_r    <= ox_nxt;
    oy_r    <= oy_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = OUT_TDATA_W'({oy_r, ox_r});
  assign out_tuser  = opv_r;
  assign out_tlast  = olast_r;

endmodule

[rtl/line_pixel_stepper_unit.sv]
`timescale 1ns / 1ps
// Channel  Dir  Carries
// in_*     in   commands: tuser = opcode, tdata = x_start, y_start, x_end, y_end
// out_*    out  pixels: tdata = pixel_x, pixel_y, tuser = pixel_valid, tlast = last
//
// One transaction per clock in each direction, sustained while out_tready stays high.
// An accepted command is written into the two-entry command queue; the step unit
// pops it from there into the output register once that register is free or read.
// Reset (synchronous) empties the queue, clears the line state and the output valid.
// With out_tready low the output register holds one result and the queue two more
// commands, then in_tready drops.

module line_pixel_stepper_unit import lps_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_tvalid,
  output logic                                      in_tready,
  // x_start, y_start, x_end, y_end
  input  logic [((4 * COORD_BITS + 7) / 8) * 8-1:0] in_tdata,
  // opcode
  input  logic                                      in_tuser,
  output logic                                      out_tvalid,
  input  logic                                      out_tready,
  // pixel_x, pixel_y
  output logic [((2 * COORD_BITS + 7) / 8) * 8-1:0] out_tdata,
  // pixel_valid
  output logic                                      out_tuser,
  output logic                                      out_tlast
);

  localparam int ENTRY_W     = 6 * COORD_BITS + 4;
  localparam int IN_TDATA_W  = ((4 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((2 * COORD_BITS + 7) / 8) * 8;

  logic               q_full, q_push, q_pop, q_valid;
  logic [ENTRY_W-1:0] q_wdata, q_rdata;

  lps_front #(
    .CB         (COORD_BITS),
    .ENTRY_W    (ENTRY_W),
    .IN_TDATA_W (IN_TDATA_W)
  ) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  lps_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  lps_back #(
    .CB          (COORD_BITS),
    .ENTRY_W     (ENTRY_W),
    .OUT_TDATA_W (OUT_TDATA_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_last_is_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser)
    else $error("last flag on a non-pixel result");

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("idle step result carries coordinates");

  a_push_when_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("queue written while full");

endmodule

[tb/sv/tb_line_pixel_stepper_unit.sv]
`timescale 1ns / 1ps

module tb_line_pixel_stepper_unit;
  import lps_pkg::*;

  localparam int COORD_BITS = 12;
  localparam int IN_W = ((4 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_W = ((2 * COORD_BITS + 7) / 8) * 8;
  localparam int CYCLE_LIMIT = 500000;
  localparam int COORD_MAX = (1 << (COORD_BITS - 1)) - 1;
  localparam int COORD_MIN = -(1 << (COORD_BITS - 1));

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct {
    coord_t x;
    coord_t y;
    logic   valid;
    logic   last;
  } pixel_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_tvalid = 1'b0;
  logic            in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic            in_tuser = 1'b0;
  logic            out_tvalid;
  logic            out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic            out_tuser;
  logic            out_tlast;

  // line walker state
  coord_t                      walk_x, walk_y, stop_x, stop_y;
  logic [COORD_BITS-1:0]       run_x, run_y;
  logic                        x_dec, y_dec;
  logic signed [COORD_BITS+1:0] bres_err;
  logic                        line_busy;

  pixel_t pixel_q[$];
  pixel_t head_px;

  int  errors = 0;
  int  cycles = 0;
  int  cmds_sent = 0;
  int  pixels_checked = 0;
  int  lines_started = 0;
  int  hold_cycles = 0;
  int  rx_gap = 0;
  bit  gaps_on = 1'b1;

  line_pixel_stepper_unit #(.COORD_BITS(COORD_BITS)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  function automatic void clear_walker();
    walk_x = '0; walk_y = '0; stop_x = '0; stop_y = '0;
    run_x = '0; run_y = '0; x_dec = 1'b0; y_dec = 1'b0;
    bres_err = '0; line_busy = 1'b0;
  endfunction

  function automatic pixel_t trace_pixel(op_t op, coord_t xs, coord_t ys,
                                         coord_t xe, coord_t ye);
    pixel_t px;
    int     dx, dy, err, e2, sx, sy;
    if (op == OP_START) begin
      dx = int'(xe) - int'(xs);
      dy = int'(ye) - int'(ys);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      walk_x = xs; walk_y = ys; stop_x = xe; stop_y = ye;
      run_x = COORD_BITS'(dx);
      run_y = COORD_BITS'(dy);
      x_dec = !(xs < xe);
      y_dec = !(ys < ye);
      bres_err = (COORD_BITS + 2)'(dx - dy);
      line_busy = (xs != xe) || (ys != ye);
      px.x = xe; px.y = ye; px.valid = 1'b1; px.last = !line_busy;
      return px;
    end
    if (!line_busy) begin
      px.x = '0; px.y = '0; px.valid = 1'b0; px.last = 1'b0;
      return px;
    end
    px.x = walk_x; px.y = walk_y; px.valid = 1'b1;
    sx = int'(run_x);
    sy = int'(run_y);
    err = int'(bres_err);
    e2 = err * 2;
    if (e2 > -sy) begin
      err -= sy;
      walk_x = x_dec ? walk_x - 1'b1 : walk_x + 1'b1;
    end
    if (e2 < sx) begin
      err += sx;
      walk_y = y_dec ? walk_y - 1'b1 : walk_y + 1'b1;
    end
    bres_err = (COORD_BITS + 2)'(err);
    px.last = (walk_x == stop_x) && (walk_y == stop_y);
    if (px.last) line_busy = 1'b0;
    return px;
  endfunction

  function automatic coord_t rand_coord();
    return coord_t'($urandom);
  endfunction

  // sender: leaves in_tvalid high after the transaction so back-to-back commands stay valid
  task automatic send_cmd(input op_t op, input coord_t xs, input coord_t ys,
                          input coord_t xe, input coord_t ye, output logic fin);
    pixel_t px;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= IN_W'({ye, xe, ys, xs});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    px = trace_pixel(op, xs, ys, xe, ye);
    pixel_q.push_back(px);
    fin = px.last;
    cmds_sent++;
    if (op == OP_START) lines_started++;
    @(negedge clk);
  endtask

  task automatic send_step(output logic fin);
    send_cmd(OP_STEP, rand_coord(), rand_coord(), rand_coord(), rand_coord(), fin);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pixel_q.size() != 0) @(negedge clk);
  endtask

  task automatic walk_line(input coord_t xs, input coord_t ys, input coord_t xe,
                           input coord_t ye, input int max_steps);
    logic fin;
    int   n;
    send_cmd(OP_START, xs, ys, xe, ye, fin);
    n = 0;
    while (!fin && (max_steps == 0 || n < max_steps)) begin
      send_step(fin);
      n++;
    end
  endtask

  task automatic draw_random_line(input int max_span, input int cut);
    int xs, ys, xe, ye, dx, dy;
    xs = $urandom_range(0, COORD_MAX - COORD_MIN) + COORD_MIN;
    ys = $urandom_range(0, COORD_MAX - COORD_MIN) + COORD_MIN;
    dx = $urandom_range(0, 2 * max_span) - max_span;
    dy = $urandom_range(0, 2 * max_span) - max_span;
    xe = xs + dx;
    ye = ys + dy;
    if (xe > COORD_MAX || xe < COORD_MIN) xe = xs - dx;
    if (ye > COORD_MAX || ye < COORD_MIN) ye = ys - dy;
    walk_line(coord_t'(xs), coord_t'(ys), coord_t'(xe), coord_t'(ye), cut);
  endtask

  task automatic test_idle_steps();
    logic fin;
    send_step(fin);
    send_cmd(OP_STEP, coord_t'(COORD_MAX), coord_t'(COORD_MIN), coord_t'(-1), '0, fin);
  endtask

  task automatic test_degenerate();
    logic fin;
    send_cmd(OP_START, coord_t'(COORD_MAX), coord_t'(COORD_MIN), coord_t'(COORD_MAX),
             coord_t'(COORD_MIN), fin);
    send_step(fin);
  endtask

  task automatic test_extremes();
    // each of these is cut short by the next start
    walk_line(coord_t'(COORD_MIN), coord_t'(COORD_MIN), coord_t'(COORD_MAX),
              coord_t'(COORD_MAX), 2);
    walk_line(coord_t'(COORD_MAX), coord_t'(COORD_MAX), coord_t'(COORD_MIN),
              coord_t'(COORD_MIN), 2);
    walk_line(coord_t'(COORD_MAX), coord_t'(COORD_MIN), coord_t'(COORD_MIN),
              coord_t'(COORD_MAX), 1);
  endtask

  task automatic test_short_lines();
    walk_line('0, '0, coord_t'(3), '0, 0);
    walk_line(coord_t'(5), coord_t'(5), coord_t'(5), coord_t'(2), 0);
    walk_line(coord_t'(-1), coord_t'(1), coord_t'(-3), coord_t'(-1), 0);
  endtask

  task automatic test_backpressure();
    logic fin;
    hold_cycles = 60;
    draw_random_line(10, 0);
    repeat (12) send_step(fin);
    wait_drained();
  endtask

  task automatic test_random_lines(input int target);
    int   pick;
    logic fin;
    while (cmds_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 70)
        draw_random_line(12, 0);
      else if (pick < 78)
        draw_random_line(12, $urandom_range(1, 6));
      else if (pick < 86)
        draw_random_line(200, $urandom_range(1, 30));
      else if (pick < 90)
        draw_random_line(COORD_MAX - COORD_MIN, $urandom_range(1, 30));
      else
        send_cmd(op_t'($urandom_range(0, 1)), rand_coord(), rand_coord(), rand_coord(),
                 rand_coord(), fin);
      if ($urandom_range(0, 5) == 0) send_step(fin);
    end
  endtask

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_tready <= 1'b0;
    end else if (gaps_on && rx_gap > 0) begin
      rx_gap--;
      out_tready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 7) == 0) begin
      rx_gap = $urandom_range(0, 11);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pixel_q.size() == 0) begin
        $error("unexpected pixel x=%0d y=%0d valid=%0b last=%0b",
               $signed(out_tdata[COORD_BITS-1:0]),
               $signed(out_tdata[2*COORD_BITS-1:COORD_BITS]), out_tuser, out_tlast);
        errors++;
      end else begin
        head_px = pixel_q.pop_front();
        pixels_checked++;
        if ($signed(out_tdata[COORD_BITS-1:0]) !== head_px.x) begin
          $error("pixel_x: expected %0d, got %0d", head_px.x,
                 $signed(out_tdata[COORD_BITS-1:0]));
          errors++;
        end
        if ($signed(out_tdata[2*COORD_BITS-1:COORD_BITS]) !== head_px.y) begin
          $error("pixel_y: expected %0d, got %0d", head_px.y,
                 $signed(out_tdata[2*COORD_BITS-1:COORD_BITS]));
          errors++;
        end
        if (out_tuser !== head_px.valid) begin
          $error("pixel_valid: expected %0b, got %0b", head_px.valid, out_tuser);
          errors++;
        end
        if (out_tlast !== head_px.last) begin
          $error("last: expected %0b, got %0b", head_px.last, out_tlast);
          errors++;
        end
      end
    end
  end

  initial begin
    clear_walker();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_idle_steps();
    test_degenerate();
    test_extremes();
    test_short_lines();
    test_backpressure();
    test_random_lines(1200);
    wait_drained();
    gaps_on = 1'b0;
    test_random_lines(1320);

    wait_drained();
    repeat (8) @(posedge clk);
    if (pixel_q.size() != 0) begin
      $error("%0d pixels never arrived", pixel_q.size());
      errors++;
    end
    $display("Sent %0d commands (%0d line starts), checked %0d pixels, %0d mismatches",
             cmds_sent, lines_started, pixels_checked, errors);
    $display("Covered idle steps, single-point and full-range lines, abandoned lines, stalls");
    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
